### design/utf8dec_pkg.sv
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dec_pkg;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'h0023;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;

  // Decoder outcome for one input word: up to two result words plus the
  // sequence state that follows the word.
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic [1:0]  pend_next;
    logic [9:0]  partial_next;
  } dec_result_t;

endpackage

`default_nettype wire

### design/utf8dec_decode.sv
// ----------------------------------------------------------------------------
// utf8dec_decode
// Combinational byte classifier and sequence accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dec_decode (
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_string,
  input  wire logic [1:0]              bytes_pending,
  input  wire logic [9:0]              partial_value,
  output utf8dec_pkg::dec_result_t     result
);

  logic        is_cont;
  logic        broken;
  logic [1:0]  pend_eff;
  logic [15:0] acc;
  logic [1:0]  pend_dec;
  logic        fresh_emit;
  logic [15:0] fresh_unit;
  logic [1:0]  pend_new;
  logic [9:0]  partial_new;

  assign is_cont  = (data_byte & utf8dec_pkg::CONT_MASK) == utf8dec_pkg::CONT_MARK;
  assign broken   = (bytes_pending != 2'd0) && !is_cont;
  assign pend_eff = broken ? 2'd0 : bytes_pending;
  assign acc      = {partial_value, data_byte[5:0]};
  assign pend_dec = pend_eff - 2'd1;

  // Handle the byte afresh, after any broken sequence has been flagged.
  always_comb begin
    fresh_emit  = 1'b0;
    fresh_unit  = utf8dec_pkg::REPLACEMENT_UNIT;
    pend_new    = pend_eff;
    partial_new = partial_value;
    if (!data_byte[7]) begin
      fresh_emit = 1'b1;
      fresh_unit = {8'd0, data_byte};
    end else if (is_cont) begin
      if (pend_eff == 2'd0) begin
        fresh_emit = 1'b1;
      end else begin
        pend_new    = pend_dec;
        partial_new = acc[9:0];
        fresh_emit  = (pend_dec == 2'd0);
        fresh_unit  = acc;
      end
    end else if ((data_byte & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_MARK) begin
      pend_new    = 2'd1;
      partial_new = {5'd0, data_byte[4:0]};
    end else if ((data_byte & utf8dec_pkg::LEAD3_MASK) == utf8dec_pkg::LEAD3_MARK) begin
      pend_new    = 2'd2;
      partial_new = {6'd0, data_byte[3:0]};
    end else begin
      fresh_emit = 1'b1;
      pend_new   = 2'd0;
    end
  end

  always_comb begin
    result.count        = {1'b0, broken} + {1'b0, fresh_emit};
    result.unit0        = broken ? utf8dec_pkg::REPLACEMENT_UNIT : fresh_unit;
    result.unit1        = fresh_unit;
    result.pend_next    = end_of_string ? 2'd0 : pend_new;
    result.partial_next = end_of_string ? 10'd0 : partial_new;
  end

endmodule

`default_nettype wire

### design/utf8dec_outbuf.sv
// ----------------------------------------------------------------------------
// utf8dec_outbuf
// Two-entry result register that presents decoded words one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8dec_outbuf (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire utf8dec_pkg::dec_result_t result,
  output logic                         free,
  output logic                         unit_valid,
  input  wire logic                    unit_ready,
  output logic [15:0]                  code_unit,
  output logic                         last_of_run
);

  logic [1:0]  res_cnt;
  logic [1:0]  res_cnt_next;
  logic [15:0] res_u0;
  logic [15:0] res_u1;
  logic        out_fire;

  assign out_fire    = unit_valid && unit_ready;
  assign unit_valid  = res_cnt != 2'd0;
  assign code_unit   = res_u0;
  // The entry left alone in the buffer is always the last word of its byte.
  assign last_of_run = res_cnt == 2'd1;
  assign free        = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_fire);

  always_comb begin
    res_cnt_next = res_cnt;
    if (load) begin
      res_cnt_next = result.count;
    end else if (out_fire) begin
      res_cnt_next = res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else begin
      res_cnt <= res_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_u0 <= result.unit0;
      res_u1 <= result.unit1;
    end else if (out_fire) begin
      res_u0 <= res_u1;
    end
  end

endmodule

`default_nettype wire

### design/utf8_to_ucs2_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Path: an accepted byte word is held in the input register, decoded there,
//   and its code units are loaded into the result register, which offers them.
// Throughput: one byte per cycle while the result register is free; a byte that
//   yields two code units holds it until both leave by the single output port.
// Reset: synchronous active-high rst empties both registers and clears the
//   pending-continuation count and the partial accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_string,
  output logic             unit_valid,
  input  wire logic        unit_ready,
  output logic [15:0]      code_unit,
  output logic             last_of_run
);

  // Input register. It holds one byte word until the decoder can retire it.
  logic       ivalid;
  logic [7:0] ibyte;
  logic       ieos;

  // Sequence state carried between bytes.
  logic [1:0] bytes_pending;
  logic [9:0] partial_value;

  utf8dec_pkg::dec_result_t dec;
  logic                     res_free;
  logic                     advance;
  logic                     load;

  utf8dec_decode u_decode (
    .data_byte     (ibyte),
    .end_of_string (ieos),
    .bytes_pending (bytes_pending),
    .partial_value (partial_value),
    .result        (dec)
  );

  // A byte that produces no code unit (a lead byte or a mid-sequence
  // continuation) retires without touching the result register, so it never
  // waits on the output side.
  assign advance    = ivalid && ((dec.count == 2'd0) || res_free);
  assign load       = advance && (dec.count != 2'd0);
  assign byte_ready = !ivalid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (byte_ready) begin
      ivalid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      ibyte <= data_byte;
      ieos  <= end_of_string;
    end
  end

  // The state only moves when the byte in the input register retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= 10'd0;
    end else if (advance) begin
      bytes_pending <= dec.pend_next;
      partial_value <= dec.partial_next;
    end
  end

  utf8dec_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .result      (dec),
    .free        (res_free),
    .unit_valid  (unit_valid),
    .unit_ready  (unit_ready),
    .code_unit   (code_unit),
    .last_of_run (last_of_run)
  );

  // The count only ever steps down from a three-byte lead.
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != 2'd3)
    else $error("bytes_pending reached an unused code");

  // The end-of-string flag leaves no partial sequence behind.
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && ieos) |=> (bytes_pending == 2'd0 && partial_value == 10'd0))
    else $error("partial sequence survived end of string");

  // Two units from one byte only happen for a broken sequence, flagged first.
  a_pair_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd2) |-> (dec.unit0 == utf8dec_pkg::REPLACEMENT_UNIT))
    else $error("two results without a leading replacement unit");

  // The first of a pair is offered next cycle and is not marked last.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd2) |=> (unit_valid && !last_of_run))
    else $error("first unit of a pair marked last");

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_to_ucs2_decoder. Byte words are offered on the
// input channel and every accepted one is run through a software decoder that
// keeps its own pending count and partial accumulator. The code unit words
// that come out are checked field by field, in order, against the units that
// the software decoder predicted. Stimulus starts with a short directed
// string, then runs mostly well-formed random text through phases with
// different idle and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet stretch tolerated before the run is declared hung. The long
  // receiver hold-off stalls both channels, so this sits well above
  // HOLD_CYCLES.
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;

  // One expected code unit word together with its end-of-run flag.
  typedef struct {
    logic [15:0] unit;
    logic        last;
  } unit_word_t;

  // Software decoder plus the queue of code units it has predicted but not
  // yet seen. Its state mirrors the block: continuations still owed and the
  // bits gathered so far.
  class decode_checker;
    logic [1:0]  owed;
    logic [9:0]  gathered;
    unit_word_t  expected_units[$];
    int          mismatches;

    function new();
      owed       = '0;
      gathered   = '0;
      mismatches = 0;
    endfunction

    // Called once per accepted byte word. Works out the zero, one or two code
    // units that the byte causes and queues them in order.
    function void note_byte(logic [7:0] b, logic eos);
      logic [15:0] units[2];
      logic [15:0] acc;
      logic        cont;
      int          n;
      unit_word_t  w;
      n    = 0;
      cont = (b & utf8dec_pkg::CONT_MASK) == utf8dec_pkg::CONT_MARK;
      // A sequence cut short by anything but a continuation is flagged first;
      // the byte is then decoded as if nothing were pending.
      if (owed != 0 && !cont) begin
        units[n] = utf8dec_pkg::REPLACEMENT_UNIT;
        n++;
        owed = '0;
      end
      if (!b[7]) begin
        units[n] = {8'h00, b};
        n++;
      end else if (cont) begin
        if (owed == 0) begin
          // Continuation with no lead in front of it: flagged and dropped.
          units[n] = utf8dec_pkg::REPLACEMENT_UNIT;
          n++;
        end else begin
          acc  = {gathered, b[5:0]};
          owed = owed - 2'd1;
          if (owed == 0) begin
            units[n] = acc;
            n++;
          end
          gathered = acc[9:0];
        end
      end else if ((b & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_MARK) begin
        gathered = {5'b0, b[4:0]};
        owed     = 2'd1;
      end else if ((b & utf8dec_pkg::LEAD3_MASK) == utf8dec_pkg::LEAD3_MARK) begin
        gathered = {6'b0, b[3:0]};
        owed     = 2'd2;
      end else begin
        // Four-byte leads and 0xF8..0xFF lie outside the BMP-only scheme.
        owed     = '0;
        units[n] = utf8dec_pkg::REPLACEMENT_UNIT;
        n++;
      end
      // The end of a string silently throws away an unfinished sequence.
      if (eos) begin
        owed     = '0;
        gathered = '0;
      end
      for (int i = 0; i < n; i++) begin
        w.unit = units[i];
        w.last = (i == n - 1);
        expected_units.push_back(w);
      end
    endfunction

    // Called once per accepted code unit word.
    function void check_unit(logic [15:0] unit, logic last);
      unit_word_t w;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected code unit %h last %b", $realtime, unit, last);
        return;
      end
      w = expected_units.pop_front();
      if (unit !== w.unit || last !== w.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: code unit mismatch: expected %h last %b, got %h last %b",
                   $realtime, w.unit, w.last, unit, last);
      end
    endfunction

    function int outstanding();
      return expected_units.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        unit_valid;
  logic        unit_ready = 1'b0;
  logic [15:0] code_unit;
  logic        last_of_run;

  // Percent of cycles in which the sender stays idle and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Bumped by the main sequence to ask the receiver for one long hold-off.
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  int quiet_cycles = 0;

  decode_checker checker_h = new();

  utf8_to_ucs2_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .unit_valid    (unit_valid),
    .unit_ready    (unit_ready),
    .code_unit     (code_unit),
    .last_of_run   (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Receiver: checks every accepted code unit word and drives ready. Values
  // read at the rising edge are the ones from before the edge, so a word is
  // taken exactly when the block sees the handshake.
  always @(posedge clk) begin
    if (!rst && unit_valid && unit_ready)
      checker_h.check_unit(code_unit, last_of_run);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      unit_ready <= 1'b0;
    end else begin
      unit_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (unit_valid && unit_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte word and returns at the edge that accepts it. Valid is
  // left high so the next call can keep it up without a dip; a random gap
  // lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid    <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    do
      @(posedge clk);
    while (!byte_ready);
    checker_h.note_byte(b, eos);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Random text: mostly complete one-, two- and three-byte characters with
  // random payload bits, mixed with cut-short sequences, stray continuations,
  // unsupported leads and raw noise. A few bytes close the string.
  task automatic send_text(input int n_bytes);
    logic [7:0] seq[3];
    int         len;
    int         pick;
    int         sent;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        seq[0] = 8'($urandom_range(127));
        len    = 1;
      end else if (pick < 55) begin
        seq[0] = 8'hC0 | 8'($urandom_range(31));
        seq[1] = cont_byte();
        len    = 2;
      end else if (pick < 75) begin
        seq[0] = 8'hE0 | 8'($urandom_range(15));
        seq[1] = cont_byte();
        seq[2] = cont_byte();
        len    = 3;
      end else if (pick < 83) begin
        // Lead with too few continuations; a following non-continuation byte breaks it.
        if ($urandom_range(1)) begin
          seq[0] = 8'hC0 | 8'($urandom_range(31));
          len    = 1;
        end else begin
          seq[0] = 8'hE0 | 8'($urandom_range(15));
          seq[1] = cont_byte();
          len    = 1 + $urandom_range(1);
        end
      end else if (pick < 88) begin
        seq[0] = cont_byte();
        len    = 1;
      end else if (pick < 92) begin
        seq[0] = 8'($urandom_range(255, 240));
        len    = 1;
      end else begin
        seq[0] = 8'($urandom_range(255));
        len    = 1;
      end
      for (int i = 0; i < len; i++)
        send_byte(seq[i], $urandom_range(99) < 3);
      sent += len;
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed string: ASCII extremes, a two-byte character, the largest
    // three-byte value, a surrogate and an overlong form that pass through
    // unchecked, a stray continuation, sequences broken by ASCII, by a new
    // lead and by an unsupported lead, the unsupported leads alone, and an
    // unfinished sequence thrown away by the end of the string.
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hF5, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);

    // Random text under each idling pattern.
    set_idling(0, 0);
    send_text(PHASE_BYTES);
    set_idling(63, 0);
    send_text(PHASE_BYTES);
    set_idling(0, 63);
    send_text(PHASE_BYTES);
    set_idling(13, 13);
    send_text(PHASE_BYTES);

    // The receiver holds off for a long stretch while bytes keep coming, so
    // the block fills up and has to stall its input.
    set_idling(0, 0);
    hold_token <= hold_token + 1;
    send_text(PHASE_BYTES);

    byte_valid <= 1'b0;
    while (checker_h.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (checker_h.mismatches == 0 && checker_h.outstanding() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
design/utf8dec_pkg.sv
design/utf8dec_decode.sv
design/utf8dec_outbuf.sv
design/utf8_to_ucs2_decoder.sv
bench/testbench.sv
